// ===== rtl/vbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vbs_pkg
// Types and constants shared by the voice budget selector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vbs_pkg;

    localparam int MAX_VOICES = 32;
    localparam int IDX_W      = $clog2(MAX_VOICES);
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);
    localparam int AUD_W      = 24;
    localparam int CFG_W      = 6;

    localparam logic [AUD_W-1:0] AUD_MAX = {AUD_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PROMOTE = 2'd1,
        ACT_DEMOTE  = 2'd2
    } t_vbs_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_MUL,
        S_STORE,
        S_INIT,
        S_RANK,
        S_EMIT
    } t_vbs_state;

    typedef struct packed {
        logic [7:0]  priority_req;
        logic [15:0] gain;
        logic [15:0] spatial_gain;
        logic [15:0] spatial_blend;
        logic [15:0] bus_gain;
        logic [31:0] creation_order;
        logic        is_paused;
        logic        is_finished;
        logic        is_bound;
        logic        is_virtual;
        logic        last_voice;
    } t_vbs_req;

    typedef struct packed {
        logic [IDX_W-1:0] voice_index;
        t_vbs_action      action;
        logic [AUD_W-1:0] audibility;
        logic             last_result;
    } t_vbs_result;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] order;
        logic        paused;
        logic        finished;
        logic        bound;
        logic        virt;
        logic        cand;
    } t_vbs_rec;

    typedef struct packed {
        logic             valid;
        logic [31:0]      key;
        logic [31:0]      order;
        logic [IDX_W-1:0] idx;
    } t_vbs_trav;

    typedef struct packed {
        logic rank_init;
        logic rank_en;
        logic shift;
    } t_vbs_ctrl;

endpackage

`default_nettype wire

// ===== rtl/vbs_aud.sv =====
// ----------------------------------------------------------------------------
// vbs_aud
// Three-stage audibility pipeline: gain * mix(blend, spatial) * bus_gain,
// truncated to Q1.23 and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_aud
    import vbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire t_vbs_req         i_req,
    output logic      [AUD_W-1:0] o_aud
);

    localparam logic [15:0] UNITY = 16'd32768;

    logic [15:0] w_s;
    logic [15:0] w_b;
    logic [15:0] w_bus;
    logic [30:0] w_mix;

    logic [30:0] r_bs;
    logic [15:0] r_binv;
    logic [15:0] r_g;
    logic [15:0] r_bus;
    logic [46:0] r_gm;
    logic [15:0] r_bus2;
    logic [62:0] r_prod;

    assign w_s   = (i_req.spatial_gain  > UNITY) ? UNITY : i_req.spatial_gain;
    assign w_b   = (i_req.spatial_blend > UNITY) ? UNITY : i_req.spatial_blend;
    assign w_bus = (i_req.bus_gain      > UNITY) ? UNITY : i_req.bus_gain;

    assign w_mix = {r_binv, 15'd0} + r_bs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bs   <= 31'(w_b) * 31'(w_s);
            r_binv <= UNITY - w_b;
            r_g    <= i_req.gain;
            r_bus  <= w_bus;
        end
        r_gm   <= 47'(r_g) * 47'(w_mix);
        r_bus2 <= r_bus;
        r_prod <= 63'(r_gm) * 63'(r_bus2);
    end

    assign o_aud = (|r_prod[62:61]) ? AUD_MAX : r_prod[60:37];

endmodule

`default_nettype wire

// ===== rtl/vbs_cell.sv =====
// ----------------------------------------------------------------------------
// vbs_cell
// One voice slot: holds a record and its rank, compares against the
// record passing by on the ring, and hands records to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_cell
    import vbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_vbs_ctrl        i_ctrl,
    input  wire logic             i_load,
    input  wire t_vbs_rec         i_rec,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic             i_occupied,
    input  wire t_vbs_rec         i_nbr_rec,
    input  wire logic [IDX_W-1:0] i_nbr_rank,
    input  wire t_vbs_trav        i_nbr_trav,
    output t_vbs_rec              o_rec,
    output logic      [IDX_W-1:0] o_rank,
    output t_vbs_trav             o_trav
);

    t_vbs_rec         r_rec;
    logic [IDX_W-1:0] r_rank;
    t_vbs_trav        r_trav;
    logic             w_before;

    assign w_before = (r_trav.key < r_rec.key) ||
                      ((r_trav.key == r_rec.key) &&
                       ((r_trav.order < r_rec.order) ||
                        ((r_trav.order == r_rec.order) && (r_trav.idx < i_idx))));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end else if (i_ctrl.shift) begin
            r_rec  <= i_nbr_rec;
            r_rank <= i_nbr_rank;
        end else if (i_ctrl.rank_init) begin
            r_rank       <= '0;
            r_trav.valid <= r_rec.cand && i_occupied;
            r_trav.key   <= r_rec.key;
            r_trav.order <= r_rec.order;
            r_trav.idx   <= i_idx;
        end else if (i_ctrl.rank_en) begin
            if (r_trav.valid && r_rec.cand && w_before) begin
                r_rank <= r_rank + 1'b1;
            end
            r_trav <= i_nbr_trav;
        end
    end

    assign o_rec  = r_rec;
    assign o_rank = r_rank;
    assign o_trav = r_trav;

endmodule

`default_nettype wire

// ===== rtl/voice_budget_selector.sv =====
// ----------------------------------------------------------------------------
// voice_budget_selector
// Ranks a set of voice records and emits one action (promote, demote or none) per voice.
// ----------------------------------------------------------------------------
// Usage:
//   Present a voice record on i_req with i_start high; it is taken at an edge
//   where o_busy is low. Each record occupies the block while it passes the
//   three multiplier stages of the audibility pipeline and is stored into its
//   cell, so a new record is not taken until the last one has been stored.
//   The record with last_voice set starts the run: an init state, then a rank
//   phase in which every record travels once around the ring of cells while
//   each cell counts those that rank ahead of it, then one result per stored
//   voice, one per cycle, in load order, shifted out of the first cell.
//   The results are registered out of the emit state that follows the rank
//   phase; o_result_valid strobes each one for a single cycle and
//   last_result marks the final one.
//   Records beyond MAX_VOICES in one set are dropped.
//   The receiver cannot stall; results are never held.
//   i_cfg_we writes max_real_voices; do so only while idle.
//   Reset empties the set, clears the strobe and sets the budget to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_budget_selector
    import vbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire t_vbs_req         i_req,
    output logic                  o_result_valid,
    output t_vbs_result           o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    t_vbs_state       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [CFG_W-1:0] r_max_real;
    t_vbs_req         r_req;
    logic             r_res_valid, n_res_valid;
    t_vbs_result      r_res, n_res;

    t_vbs_ctrl        w_ctrl;
    logic             w_accept;
    logic             w_store;
    logic [AUD_W-1:0] w_aud;
    t_vbs_rec         w_new;
    logic             w_sel;

    t_vbs_rec         w_rec  [MAX_VOICES];
    logic [IDX_W-1:0] w_rank [MAX_VOICES];
    t_vbs_trav        w_trav [MAX_VOICES];

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    vbs_aud u_aud (
        .i_clk (i_clk),
        .i_en  (w_accept),
        .i_req (i_req),
        .o_aud (w_aud)
    );

    assign w_new.key      = {r_req.priority_req, AUD_MAX - w_aud};
    assign w_new.order    = r_req.creation_order;
    assign w_new.paused   = r_req.is_paused;
    assign w_new.finished = r_req.is_finished;
    assign w_new.bound    = r_req.is_bound;
    assign w_new.virt     = r_req.is_virtual;
    assign w_new.cand     = !r_req.is_paused && !r_req.is_finished && (w_aud != '0);

    assign w_store = (r_state == S_STORE) && (r_count < CNT_W'(MAX_VOICES));

    for (genvar k = 0; k < MAX_VOICES; k++) begin : g_cell
        localparam int NB = (k + 1) % MAX_VOICES;
        vbs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_load     (w_store && (r_count == CNT_W'(k))),
            .i_rec      (w_new),
            .i_idx      (IDX_W'(k)),
            .i_occupied (CNT_W'(k) < r_count),
            .i_nbr_rec  (w_rec[NB]),
            .i_nbr_rank (w_rank[NB]),
            .i_nbr_trav (w_trav[NB]),
            .o_rec      (w_rec[k]),
            .o_rank     (w_rank[k]),
            .o_trav     (w_trav[k])
        );
    end

    assign w_sel = w_rec[0].cand && ({1'b0, w_rank[0]} < r_max_real);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                if (w_store) begin
                    n_count = r_count + 1'b1;
                end
                n_state = r_req.last_voice ? S_INIT : S_IDLE;
            end
            S_INIT: begin
                w_ctrl.rank_init = 1'b1;
                n_cnt            = '0;
                n_state          = S_RANK;
            end
            S_RANK: begin
                w_ctrl.rank_en = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(MAX_VOICES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_ctrl.shift      = 1'b1;
                n_res_valid       = 1'b1;
                n_res.voice_index = r_cnt;
                n_res.audibility  = AUD_MAX - w_rec[0].key[AUD_W-1:0];
                n_res.last_result = ({1'b0, r_cnt} == (r_count - 1'b1));
                priority if (w_rec[0].paused) begin
                    n_res.action = ACT_NONE;
                end else if (w_sel) begin
                    n_res.action = w_rec[0].bound ? ACT_NONE : ACT_PROMOTE;
                end else begin
                    n_res.action = (!w_rec[0].bound && w_rec[0].virt) ? ACT_NONE
                                                                     : ACT_DEMOTE;
                end
                n_cnt = r_cnt + 1'b1;
                if (n_res.last_result) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cnt       <= '0;
            r_max_real  <= CFG_W'(32);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_max_real <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

`default_nettype wire

// ===== rtl/vbs_chk.sv =====
// ----------------------------------------------------------------------------
// vbs_chk
// Port-level checks on the voice budget selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_chk
    import vbs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic             o_busy,
    input wire logic             o_result_valid,
    input wire t_vbs_result      o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not raise busy");

    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last_result) |-> o_busy)
        else $error("result run ended without last_result");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_result) |=> !o_result_valid)
        else $error("result strobe after last_result");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !$past(o_result_valid)) |-> (o_result.voice_index == '0))
        else $error("run does not start at voice 0");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid)) |->
        (o_result.voice_index == ($past(o_result.voice_index) + 5'd1)))
        else $error("voice index did not advance by one");

endmodule

bind voice_budget_selector vbs_chk u_vbs_chk (.*);

`default_nettype wire
